>>> rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;

  // Internal widths: scaled sums run up to 600000, times 255 fits in 28 bits
  localparam int SV_W        = 2 * PCT_W;
  localparam int K_W         = 6;
  localparam int SUM_W       = 20;
  localparam int N_W         = 28;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 40;
  localparam int PROD_W      = N_W + RECIP_W;

  // Register stages from accepted request to result strobe
  localparam int PIPE_DEPTH = 5;

  // Range limits and hue sector boundaries
  localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
  localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
  localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
  localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
  localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
  localparam logic [HUE_W-1:0] HUE_300 = 9'd300;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Arithmetic constants
  localparam logic [K_W-1:0]     K_FULL    = 6'd60;
  localparam logic [SUM_W-1:0]   VAL_SCALE = 20'd6000;
  localparam logic [N_W-1:0]     CH_FULL   = 28'd255;
  localparam logic [N_W-1:0]     SCALE_DEN = 28'd600000;
  // floor(2^40 / 600000)
  localparam logic [RECIP_W-1:0] DEN_RECIP = 21'd1832519;

  // Request payload
  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] value_pct;
  } hsv2rgb_in_t;

  // Result payload
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } hsv2rgb_out_t;

  // Decoded operands: channel = 255 * (base - sv * k) / 600000
  typedef struct packed {
    logic [SUM_W-1:0] base;
    logic [SV_W-1:0]  sv;
    logic [K_W-1:0]   k_red;
    logic [K_W-1:0]   k_green;
    logic [K_W-1:0]   k_blue;
  } hsv2rgb_comp_t;

  // Operands of one channel lane
  typedef struct packed {
    logic [SUM_W-1:0] base;
    logic [SV_W-1:0]  sv;
    logic [K_W-1:0]   k;
  } hsv2rgb_lane_t;

endpackage

>>> rtl/core/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// First stage: range check, hue sector decode and the S*V and V*6000 products.
// ----------------------------------------------------------------------------
module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic          clk,
  input  hsv2rgb_in_t   in_req,
  output hsv2rgb_comp_t comp
);

  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  localparam logic [6:0] HM_HALF = 7'd60;

  logic             black;
  logic [HUE_W-1:0] hue_off;
  logic [6:0]       hm;
  logic [6:0]       dist_full;
  logic [K_W-1:0]   hue_dist;
  logic [2:0]       sector;
  logic [SV_W-1:0]  sv_prod;
  logic [SUM_W-1:0] base_prod;
  hsv2rgb_comp_t    comp_nxt;
  hsv2rgb_comp_t    comp_r;

  // Out of range inputs give black
  assign black = (in_req.hue_deg > HUE_MAX) || (in_req.saturation_pct > PCT_MAX) ||
                 (in_req.value_pct > PCT_MAX);

  // Fold hue into 0..120 and take its distance from 60
  always_comb begin
    if (in_req.hue_deg >= HUE_240) begin
      hue_off = in_req.hue_deg - HUE_240;
    end else if (in_req.hue_deg >= HUE_120) begin
      hue_off = in_req.hue_deg - HUE_120;
    end else begin
      hue_off = in_req.hue_deg;
    end
  end

  assign hm        = hue_off[6:0];
  assign dist_full = (hm >= HM_HALF) ? (hm - HM_HALF) : (HM_HALF - hm);
  assign hue_dist  = dist_full[K_W-1:0];

  // Pick the 60-degree sector; hue 360 stays in the last one
  always_comb begin
    priority if (in_req.hue_deg < HUE_60) begin
      sector = SEC_RED_YEL;
    end else if (in_req.hue_deg < HUE_120) begin
      sector = SEC_YEL_GRN;
    end else if (in_req.hue_deg < HUE_180) begin
      sector = SEC_GRN_CYN;
    end else if (in_req.hue_deg < HUE_240) begin
      sector = SEC_CYN_BLU;
    end else if (in_req.hue_deg < HUE_300) begin
      sector = SEC_BLU_MAG;
    end else begin
      sector = SEC_MAG_RED;
    end
  end

  // Products shared by all three channels
  assign sv_prod   = {{PCT_W{1'b0}}, in_req.saturation_pct} *
                     {{PCT_W{1'b0}}, in_req.value_pct};
  assign base_prod = {{(SUM_W - PCT_W){1'b0}}, in_req.value_pct} * VAL_SCALE;

  // Per channel weight: 0 for chroma, hue distance for the second component, 60 for none
  always_comb begin
    comp_nxt.base = black ? '0 : base_prod;
    comp_nxt.sv   = black ? '0 : sv_prod;
    unique case (sector)
      SEC_RED_YEL: begin
        comp_nxt.k_red = '0;       comp_nxt.k_green = hue_dist; comp_nxt.k_blue = K_FULL;
      end
      SEC_YEL_GRN: begin
        comp_nxt.k_red = hue_dist; comp_nxt.k_green = '0;       comp_nxt.k_blue = K_FULL;
      end
      SEC_GRN_CYN: begin
        comp_nxt.k_red = K_FULL;   comp_nxt.k_green = '0;       comp_nxt.k_blue = hue_dist;
      end
      SEC_CYN_BLU: begin
        comp_nxt.k_red = K_FULL;   comp_nxt.k_green = hue_dist; comp_nxt.k_blue = '0;
      end
      SEC_BLU_MAG: begin
        comp_nxt.k_red = hue_dist; comp_nxt.k_green = K_FULL;   comp_nxt.k_blue = '0;
      end
      default: begin
        comp_nxt.k_red = '0;       comp_nxt.k_green = K_FULL;   comp_nxt.k_blue = hue_dist;
      end
    endcase
  end

  // Register decoded operands
  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
  end

  assign comp = comp_r;

endmodule

>>> rtl/core/hsv2rgb_lane.sv
// ----------------------------------------------------------------------------
// hsv2rgb_lane
// One colour channel: weight product, scale by 255, reciprocal divide by
// 600000 and a single correction step, over four register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_lane
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  hsv2rgb_lane_t   opnd,
  output logic [CH_W-1:0] chan
);

  logic [SUM_W-1:0]  wprod_nxt;
  logic [SUM_W-1:0]  wprod_r;
  logic [SUM_W-1:0]  base_r;
  logic [SUM_W-1:0]  sum;
  logic [N_W-1:0]    scaled_nxt;
  logic [N_W-1:0]    scaled_r;
  logic [PROD_W-1:0] rec_prod;
  logic [CH_W-1:0]   quot_nxt;
  logic [CH_W-1:0]   quot_r;
  logic [N_W-1:0]    num_r;
  logic [N_W-1:0]    approx;
  logic [N_W-1:0]    rem;
  logic [CH_W-1:0]   chan_nxt;
  logic [CH_W-1:0]   chan_r;

  // Weighted part taken off the base
  assign wprod_nxt = {{(SUM_W - SV_W){1'b0}}, opnd.sv} *
                     {{(SUM_W - K_W){1'b0}}, opnd.k};

  // Channel sum scaled to the 0..255 range, still over 600000
  assign sum        = base_r - wprod_r;
  assign scaled_nxt = {{(N_W - SUM_W){1'b0}}, sum} * CH_FULL;

  // Reciprocal estimate, at most one below the true quotient
  assign rec_prod = {{RECIP_W{1'b0}}, scaled_r} * {{N_W{1'b0}}, DEN_RECIP};
  assign quot_nxt = rec_prod[RECIP_SHIFT + CH_W - 1:RECIP_SHIFT];

  // Correct the estimate from the remainder
  assign approx   = {{(N_W - CH_W){1'b0}}, quot_r} * SCALE_DEN;
  assign rem      = num_r - approx;
  assign chan_nxt = quot_r + CH_W'(rem >= SCALE_DEN);

  // Advance the lane
  always_ff @(posedge clk) begin
    wprod_r  <= wprod_nxt;
    base_r   <= opnd.base;
    scaled_r <= scaled_nxt;
    quot_r   <= quot_nxt;
    num_r    <= scaled_r;
    chan_r   <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

>>> rtl/core/hsv_to_rgb_converter_unit.sv
// A result strobes out_valid after its request passes the five register stages:
// decode, weight product, scale, reciprocal multiply and remainder correction.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n low, synchronous) clears the valid pipeline; data regs are not reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV (degrees, percent, percent) to 8-bit RGB colour converter, top level.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  hsv2rgb_in_t  in_req,
  output logic         out_valid,
  output hsv2rgb_out_t out_rsp
);

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  hsv2rgb_comp_t         comp;
  hsv2rgb_lane_t         lane_red;
  hsv2rgb_lane_t         lane_green;
  hsv2rgb_lane_t         lane_blue;
  logic [CH_W-1:0]       chan_red;
  logic [CH_W-1:0]       chan_green;
  logic [CH_W-1:0]       chan_blue;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Shift valid bits alongside the data
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Decode stage
  hsv2rgb_front u_front (
    .clk    (clk),
    .in_req (in_req),
    .comp   (comp)
  );

  // Split operands per channel
  assign lane_red   = '{base: comp.base, sv: comp.sv, k: comp.k_red};
  assign lane_green = '{base: comp.base, sv: comp.sv, k: comp.k_green};
  assign lane_blue  = '{base: comp.base, sv: comp.sv, k: comp.k_blue};

  hsv2rgb_lane u_lane_red (
    .clk  (clk),
    .opnd (lane_red),
    .chan (chan_red)
  );

  hsv2rgb_lane u_lane_green (
    .clk  (clk),
    .opnd (lane_green),
    .chan (chan_green)
  );

  hsv2rgb_lane u_lane_blue (
    .clk  (clk),
    .opnd (lane_blue),
    .chan (chan_blue)
  );

  // Drive results
  assign out_valid     = vld_r[PIPE_DEPTH-1];
  assign out_rsp.red   = chan_red;
  assign out_rsp.green = chan_green;
  assign out_rsp.blue  = chan_blue;

  // Every accepted request gives one result at the end of the pipeline
  a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_DEPTH out_valid)
    else $error("request without result after pipeline latency");

  // No result without a request the same latency earlier
  a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_DEPTH))
    else $error("result strobe without matching request");

  // Hue out of range gives black
  a_hue_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && (in_req.hue_deg > HUE_MAX), PIPE_DEPTH))
      |-> (out_rsp == '0))
    else $error("out of range hue did not give black");

  // Zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && (in_req.saturation_pct == '0), PIPE_DEPTH))
      |-> ((out_rsp.red == out_rsp.green) && (out_rsp.green == out_rsp.blue)))
    else $error("zero saturation did not give grey");

endmodule
